// ===== sv/ppu_scroll_address_registers_assert.svh =====
// assertion macros used by the port checker
`ifndef PPU_SCROLL_ADDRESS_REGISTERS_ASSERT_SVH
`define PPU_SCROLL_ADDRESS_REGISTERS_ASSERT_SVH

// condition must hold in the same cycle as the antecedent
`define PSAR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scroll register check failed");

// condition must hold in the cycle after the antecedent
`define PSAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scroll register check failed");

`endif

// ===== sv/psar_pkg.sv =====
// ------------------------------------------------------------------------
// psar_pkg
// Types and constants shared by the scroll address register block.
// ------------------------------------------------------------------------
package psar_pkg;

   // transaction action codes
   typedef enum logic [3:0] {
      ACT_CTRL_WRITE   = 4'd0,
      ACT_SCROLL_WRITE = 4'd1,
      ACT_ADDR_WRITE   = 4'd2,
      ACT_DATA_ACCESS  = 4'd3,
      ACT_STATUS_READ  = 4'd4,
      ACT_COARSE_X_INC = 4'd5,
      ACT_Y_INC        = 4'd6,
      ACT_COPY_HORIZ   = 4'd7,
      ACT_COPY_VERT    = 4'd8
   } action_type;

   localparam int ADDR_W  = 15;
   localparam int VRAM_W  = 14;
   localparam int FINE_W  = 3;

   // coarse y value after which the vertical nametable flips
   localparam logic [4:0] COARSE_Y_LAST_ROW = 5'd29;
   localparam logic [4:0] COARSE_Y_MAX      = 5'd31;
   localparam logic [4:0] COARSE_X_MAX      = 5'd31;
   localparam logic [2:0] FINE_Y_MAX        = 3'd7;

   // request transaction
   typedef struct packed {
      action_type  action;
      logic [7:0]  value;
      logic        rendering;
      logic        startup_done;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [ADDR_W-1:0] current_address;
      logic [ADDR_W-1:0] temp_address;
      logic [VRAM_W-1:0] vram_address;
      logic [VRAM_W-1:0] nametable_fetch_address;
      logic [VRAM_W-1:0] attribute_fetch_address;
      logic [FINE_W-1:0] fine_x_scroll;
      logic [FINE_W-1:0] fine_y_scroll;
      logic              write_toggle;
   } rsp_type;

   // flow control between the stages
   typedef struct packed {
      logic item_valid;
      logic advance;
   } stage_ctrl_type;

endpackage

// ===== sv/psar_in_stage.sv =====
// ------------------------------------------------------------------------
// psar_in_stage
// Input register: holds one request transaction until the update stage
// can take it.
// ------------------------------------------------------------------------
module psar_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  psar_pkg::req_type req_payload,
   input  logic             out_ready,
   output psar_pkg::req_type item,
   output psar_pkg::stage_ctrl_type ctrl
);
   import psar_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    accept;
   logic    advance;

   // move on whenever the result side has room
   assign advance   = valid_ff && out_ready;
   assign req_stall = valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
   end

   assign item            = item_ff;
   assign ctrl.item_valid = valid_ff;
   assign ctrl.advance    = advance;

endmodule

// ===== sv/psar_core.sv =====
// ------------------------------------------------------------------------
// psar_core
// Holds v, t, fine x, the write toggle and the increment flag, applies one
// action per transaction and forms the result fields from the new state.
// ------------------------------------------------------------------------
module psar_core (
   input  logic                     clock,
   input  logic                     reset,
   input  psar_pkg::req_type        item,
   input  psar_pkg::stage_ctrl_type ctrl,
   output psar_pkg::rsp_type        rsp_next
);
   import psar_pkg::*;

   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0] tmp_ff, tmp_in;
   logic [FINE_W-1:0] fine_x_ff, fine_x_in;
   logic              toggle_ff, toggle_in;
   logic              step32_ff, step32_in;

   // coarse x increment with horizontal nametable wrap
   function automatic logic [ADDR_W-1:0] inc_coarse_x(input logic [ADDR_W-1:0] v);
      logic [ADDR_W-1:0] r;
      r = v;
      if (v[4:0] == COARSE_X_MAX) begin
         r[4:0] = 5'd0;
         r[10]  = ~v[10];
      end else begin
         r[4:0] = v[4:0] + 5'd1;
      end
      return r;
   endfunction

   // fine y increment rolling into coarse y and vertical nametable
   function automatic logic [ADDR_W-1:0] inc_y(input logic [ADDR_W-1:0] v);
      logic [ADDR_W-1:0] r;
      r = v;
      if (v[14:12] != FINE_Y_MAX) begin
         r[14:12] = v[14:12] + 3'd1;
      end else begin
         r[14:12] = 3'd0;
         if (v[9:5] == COARSE_Y_LAST_ROW) begin
            r[9:5] = 5'd0;
            r[11]  = ~v[11];
         end else if (v[9:5] == COARSE_Y_MAX) begin
            r[9:5] = 5'd0;
         end else begin
            r[9:5] = v[9:5] + 5'd1;
         end
      end
      return r;
   endfunction

   // next state for the action in the input register
   always_comb begin
      cur_in    = cur_ff;
      tmp_in    = tmp_ff;
      fine_x_in = fine_x_ff;
      toggle_in = toggle_ff;
      step32_in = step32_ff;
      unique case (item.action)
         ACT_CTRL_WRITE: begin
            if (item.startup_done) begin
               tmp_in[11:10] = item.value[1:0];
               step32_in     = item.value[2];
            end
         end
         ACT_SCROLL_WRITE: begin
            if (item.startup_done) begin
               if (toggle_ff) begin
                  tmp_in[14:12] = item.value[2:0];
                  tmp_in[9:5]   = item.value[7:3];
                  toggle_in     = 1'b0;
               end else begin
                  tmp_in[4:0] = item.value[7:3];
                  fine_x_in   = item.value[2:0];
                  toggle_in   = 1'b1;
               end
            end
         end
         ACT_ADDR_WRITE: begin
            if (item.startup_done) begin
               if (toggle_ff) begin
                  tmp_in[7:0] = item.value;
                  cur_in      = {tmp_ff[14:8], item.value};
                  toggle_in   = 1'b0;
               end else begin
                  tmp_in[14:8] = {1'b0, item.value[5:0]};
                  toggle_in    = 1'b1;
               end
            end
         end
         ACT_DATA_ACCESS: begin
            if (item.rendering) begin
               cur_in = inc_y(inc_coarse_x(cur_ff));
            end else if (step32_ff) begin
               cur_in = cur_ff + ADDR_W'(32);
            end else begin
               cur_in = cur_ff + ADDR_W'(1);
            end
         end
         ACT_STATUS_READ: begin
            toggle_in = 1'b0;
         end
         ACT_COARSE_X_INC: begin
            cur_in = inc_coarse_x(cur_ff);
         end
         ACT_Y_INC: begin
            cur_in = inc_y(cur_ff);
         end
         ACT_COPY_HORIZ: begin
            cur_in[10]  = tmp_ff[10];
            cur_in[4:0] = tmp_ff[4:0];
         end
         ACT_COPY_VERT: begin
            cur_in[14:11] = tmp_ff[14:11];
            cur_in[9:5]   = tmp_ff[9:5];
         end
         default: begin
         end
      endcase
   end

   // state registers, updated once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         tmp_ff    <= '0;
         fine_x_ff <= '0;
         toggle_ff <= 1'b0;
         step32_ff <= 1'b0;
      end else if (ctrl.item_valid && ctrl.advance) begin
         cur_ff    <= cur_in;
         tmp_ff    <= tmp_in;
         fine_x_ff <= fine_x_in;
         toggle_ff <= toggle_in;
         step32_ff <= step32_in;
      end
   end

   // result fields from the state after the action
   always_comb begin
      rsp_next.current_address         = cur_in;
      rsp_next.temp_address            = tmp_in;
      rsp_next.vram_address            = cur_in[13:0];
      rsp_next.nametable_fetch_address = {2'b10, cur_in[11:0]};
      rsp_next.attribute_fetch_address = {2'b10, cur_in[11:10], 4'b1111,
                                          cur_in[9:7], cur_in[4:2]};
      rsp_next.fine_x_scroll           = fine_x_in;
      rsp_next.fine_y_scroll           = cur_in[14:12];
      rsp_next.write_toggle            = toggle_in;
   end

endmodule

// ===== sv/psar_out_stage.sv =====
// ------------------------------------------------------------------------
// psar_out_stage
// Result register: presents one result transaction until it is taken.
// ------------------------------------------------------------------------
module psar_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  psar_pkg::stage_ctrl_type ctrl,
   input  psar_pkg::rsp_type        rsp_next,
   output logic                     out_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output psar_pkg::rsp_type        rsp_payload
);
   import psar_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;
   logic    load;

   // room when empty or when the held result leaves this cycle
   assign out_ready = !valid_ff || !rsp_stall;
   assign load      = ctrl.item_valid && ctrl.advance;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== sv/ppu_scroll_address_registers.sv =====
// ------------------------------------------------------------------------
// ppu_scroll_address_registers
// Scroll and VRAM address registers (v, t, fine x, write toggle) of a
// tile-based picture processor, driven by bus and render-event actions.
// ------------------------------------------------------------------------
// One action is taken per clock cycle when the result side keeps up, and
// every action gives exactly one result holding the register state after
// it. The request sits in an input register, then the update of v and t
// writes the result register. The rate is set by that update, which
// reads the state left by the previous action. While a result is stalled
// the block still takes one further request into its input register
// before it stalls the request side.
module ppu_scroll_address_registers (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psar_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output psar_pkg::rsp_type rsp_payload
);
   import psar_pkg::*;

   req_type        item;
   rsp_type        rsp_next;
   stage_ctrl_type ctrl;
   logic           out_ready;

   // request register
   psar_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .out_ready   (out_ready),
      .item        (item),
      .ctrl        (ctrl)
   );

   // register state and update logic
   psar_core u_core (
      .clock    (clock),
      .reset    (reset),
      .item     (item),
      .ctrl     (ctrl),
      .rsp_next (rsp_next)
   );

   // result register
   psar_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .rsp_next    (rsp_next),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sv/psar_checker.sv =====
// ------------------------------------------------------------------------
// psar_checker
// Port-level checks on the request and result channels of the scroll
// register block.
// ------------------------------------------------------------------------
`include "ppu_scroll_address_registers_assert.svh"

module psar_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input psar_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input psar_pkg::rsp_type rsp_payload
);
   import psar_pkg::*;

   logic req_wait;
   logic rsp_wait;
   logic vram_ok;
   logic nt_ok;
   logic fine_y_ok;

   // transaction offered but held off on either channel
   assign req_wait = req_valid && req_stall;
   assign rsp_wait = rsp_valid && rsp_stall;

   // derived fields against the full v register
   assign vram_ok   = rsp_payload.vram_address == rsp_payload.current_address[13:0];
   assign nt_ok     = rsp_payload.nametable_fetch_address ==
                      {2'b10, rsp_payload.current_address[11:0]};
   assign fine_y_ok = rsp_payload.fine_y_scroll == rsp_payload.current_address[14:12];

   // a stalled request stays put
   `PSAR_ASSERT_NEXT(a_req_hold, clock, reset, req_wait, req_valid && $stable(req_payload))

   // a stalled result stays put
   `PSAR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_payload))

   // data port address is the low part of v
   `PSAR_ASSERT_NOW(a_vram_addr, clock, reset, rsp_valid, vram_ok)

   // tile fetch address sits in the nametable window and follows v
   `PSAR_ASSERT_NOW(a_nt_addr, clock, reset, rsp_valid, nt_ok)

   // fine y is the top three bits of v
   `PSAR_ASSERT_NOW(a_fine_y, clock, reset, rsp_valid, fine_y_ok)

endmodule

bind ppu_scroll_address_registers psar_checker u_psar_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
